>>> design/bhc_pkg.sv
// Shared types and constants for the capped byte histogram.
package bhc_pkg;

    localparam int SYMBOLS_DEFAULT = 256;
    localparam int BYTE_W          = 8;
    localparam int COUNT_W         = 25;
    localparam int DISTINCT_W      = 9;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(1024 * 1024);
    localparam logic [COUNT_W-1:0] LIMIT_MAX   = COUNT_W'(16777216);

    typedef enum logic
    {
        OP_COUNT = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed
    {
        logic accept;
        logic update;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed
    {
        logic op_read;
        logic out_free;
    } dp_status_t;

endpackage

>>> design/bhc_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
module bhc_ctrl
    import bhc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!status.op_read)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/bhc_datapath.sv
// Datapath with the bin memory, running totals, limit register and output register.
module bhc_datapath
    import bhc_pkg::*;
#(
    parameter int SYMBOLS = SYMBOLS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_W-1:0]    cfg_data,
    input  logic                  operation,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [BYTE_W-1:0]     symbol,
    output logic [COUNT_W-1:0]    bin_count,
    output logic [DISTINCT_W-1:0] distinct_symbols,
    output logic [COUNT_W-1:0]    total_sampled,
    output logic                  limit_reached,
    input  dp_cmd_t               cmd,
    output dp_status_t            status
);

    localparam int AW = $clog2(SYMBOLS);
    localparam logic [BYTE_W:0] SYM_LIM = (BYTE_W + 1)'(SYMBOLS);

    logic [COUNT_W-1:0]    mem [SYMBOLS];
    logic [SYMBOLS-1:0]    valid_reg;

    logic [COUNT_W-1:0]    limit_reg;
    logic [COUNT_W-1:0]    total_reg;
    logic [DISTINCT_W-1:0] distinct_reg;

    op_t                   op_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic                  alpha_reg;
    logic [COUNT_W-1:0]    rd_data_reg;
    logic                  rd_valid_reg;

    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     symbol_reg;
    logic [COUNT_W-1:0]    bin_count_reg;
    logic [DISTINCT_W-1:0] distinct_out_reg;
    logic [COUNT_W-1:0]    total_out_reg;
    logic                  reached_out_reg;

    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  in_alpha;
    logic [COUNT_W-1:0]    eff_limit;
    logic                  below_limit;
    logic [COUNT_W-1:0]    bin_cur;
    logic                  do_count;

    assign rd_addr     = data_byte[AW-1:0];
    assign wr_addr     = byte_reg[AW-1:0];
    assign in_alpha    = ({1'b0, data_byte} < SYM_LIM);
    assign eff_limit   = (limit_reg > LIMIT_MAX) ? LIMIT_MAX : limit_reg;
    assign below_limit = (total_reg < eff_limit);
    assign bin_cur     = rd_valid_reg ? rd_data_reg : '0;
    assign do_count    = cmd.update && alpha_reg && below_limit;

    assign cfg_ready       = 1'b1;
    assign status.op_read  = (op_reg == OP_READ);
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (do_count)
        begin
            mem[wr_addr] <= bin_cur + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= op_t'(operation);
            byte_reg     <= data_byte;
            alpha_reg    <= in_alpha;
            rd_valid_reg <= in_alpha && valid_reg[rd_addr];
        end
        if (cmd.load_out)
        begin
            symbol_reg       <= byte_reg;
            bin_count_reg    <= alpha_reg ? bin_cur : '0;
            distinct_out_reg <= distinct_reg;
            total_out_reg    <= total_reg;
            reached_out_reg  <= !below_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            total_reg     <= '0;
            distinct_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (do_count)
            begin
                valid_reg[wr_addr] <= 1'b1;
                total_reg          <= total_reg + COUNT_W'(1);
                if (bin_cur == '0)
                begin
                    distinct_reg <= distinct_reg + DISTINCT_W'(1);
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign symbol           = symbol_reg;
    assign bin_count        = bin_count_reg;
    assign distinct_symbols = distinct_out_reg;
    assign total_sampled    = total_out_reg;
    assign limit_reached    = reached_out_reg;

endmodule

>>> design/byte_histogram_capped.sv
// Top level of the capped byte histogram: controller plus datapath.
// Each transaction is a memory read in the accept cycle (ST_IDLE) and the write
// back or report in ST_EXEC; in_ready is low until the state returns to ST_IDLE.
// A read result is loaded into the output register from ST_EXEC; a read
// holds ST_EXEC until the output is empty or the previous result is taken.
// Reset clears all bins through per-bin valid bits and both totals, empties the
// output and sets the limit to 1048576.
module byte_histogram_capped
    import bhc_pkg::*;
#(
    parameter int SYMBOLS = SYMBOLS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_W-1:0]    cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [BYTE_W-1:0]     data_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     symbol,
    output logic [COUNT_W-1:0]    bin_count,
    output logic [DISTINCT_W-1:0] distinct_symbols,
    output logic [COUNT_W-1:0]    total_sampled,
    output logic                  limit_reached
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bhc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bhc_datapath #(
        .SYMBOLS (SYMBOLS)
    ) u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .operation        (operation),
        .data_byte        (data_byte),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .symbol           (symbol),
        .bin_count        (bin_count),
        .distinct_symbols (distinct_symbols),
        .total_sampled    (total_sampled),
        .limit_reached    (limit_reached),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
